[hw/rtl/bayer_gr12_bilinear_demosaic_unit_macros.svh]
// Assertion macros for the demosaic unit checkers.
`ifndef BAYER_GR12_BILINEAR_DEMOSAIC_UNIT_MACROS_SVH
`define BAYER_GR12_BILINEAR_DEMOSAIC_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BGBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BGBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bgbd_pkg.sv]
// Types, constants and pixel math shared by the demosaic unit.
package bgbd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PAIR_W      = 16;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_ORDER = 2'd2;

    typedef enum logic [1:0] {
        ROW_FIRST,
        ROW_ODD,
        ROW_EVEN,
        ROW_LAST
    } row_kind_t;

    typedef logic [2:0][2:0][7:0] window_t;

    typedef struct packed {
        logic [7:0] bl;
        logic [7:0] gr;
        logic [7:0] rd;
    } rgb_t;

    typedef struct packed {
        logic       eof;
        logic       eol;
        logic [7:0] last_ch;
        logic [7:0] mid_ch;
        logic [7:0] first_ch;
    } out_item_t;

    typedef struct packed {
        logic      flush;
        logic      emit_a;
        logic      emit_b;
        row_kind_t kind;
        logic      a_first;
        logic      a_last;
        logic      a_odd;
        logic      a_eol;
        logic      a_eof;
        logic      load_pre;
    } stage_ctl_t;

    function automatic logic [7:0] avg2(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[8:1];
    endfunction

    function automatic logic [7:0] avg3(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] z);
        logic [9:0]  s;
        logic [19:0] p;
        s = {2'b0, x} + {2'b0, y} + {2'b0, z};
        p = {10'd0, s} * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] avg4(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] z, input logic [7:0] u);
        logic [9:0] s;
        s = {2'b0, x} + {2'b0, y} + {2'b0, z} + {2'b0, u};
        return s[9:2];
    endfunction

    function automatic window_t shift_win(input window_t w, input logic [7:0] t,
                                          input logic [7:0] m, input logic [7:0] b);
        window_t n;
        n = w;
        for (int i = 0; i < 3; i++) begin
            n[i][0] = w[i][1];
            n[i][1] = w[i][2];
        end
        n[0][2] = t;
        n[1][2] = m;
        n[2][2] = b;
        return n;
    endfunction

    function automatic rgb_t demosaic(input window_t w, input row_kind_t k,
                                      input logic first, input logic last,
                                      input logic odd);
        logic [7:0] al, a, ar, l, s, r, bbl, b, bbr;
        rgb_t o;
        al = w[0][0]; a = w[0][1]; ar = w[0][2];
        l  = w[1][0]; s = w[1][1]; r  = w[1][2];
        bbl = w[2][0]; b = w[2][1]; bbr = w[2][2];
        o = '0;
        case (k)
            ROW_FIRST: begin
                if (first)     o = '{b, s, r};
                else if (last) o = '{bbl, avg2(l, b), s};
                else if (odd)  o = '{avg2(bbl, bbr), avg3(l, r, b), s};
                else           o = '{b, s, avg2(l, r)};
            end
            ROW_ODD: begin
                if (first)     o = '{s, avg3(a, r, b), avg2(ar, bbr)};
                else if (last) o = '{l, s, avg2(a, b)};
                else if (odd)  o = '{avg2(l, r), s, avg2(a, b)};
                else           o = '{s, avg4(a, b, l, r), avg4(al, ar, bbl, bbr)};
            end
            ROW_EVEN: begin
                if (first)     o = '{avg2(a, b), s, r};
                else if (last) o = '{avg2(bbl, al), avg3(a, b, l), s};
                else if (odd)  o = '{avg4(al, ar, bbl, bbr), avg4(a, b, l, r), s};
                else           o = '{avg2(a, b), s, avg2(l, r)};
            end
            default: begin
                if (first)     o = '{s, avg2(a, r), ar};
                else if (last) o = '{l, s, a};
                else if (odd)  o = '{avg2(l, r), s, a};
                else           o = '{s, avg3(a, l, r), avg2(al, ar)};
            end
        endcase
        return o;
    endfunction

endpackage

[hw/rtl/bgbd_line_ram.sv]
// Line store pair memory: one write port, two registered read ports with bypass.
module bgbd_line_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 we,
    input  logic [$clog2(DEPTH)-1:0]             wa,
    input  logic [bgbd_pkg::PAIR_W-1:0]          wd,
    input  logic [$clog2(DEPTH)-1:0]             ra1,
    input  logic [$clog2(DEPTH)-1:0]             ra2,
    output logic [bgbd_pkg::PAIR_W-1:0]          rd1,
    output logic [bgbd_pkg::PAIR_W-1:0]          rd2
);
    import bgbd_pkg::*;

    logic [PAIR_W-1:0] mem [DEPTH];
    logic [PAIR_W-1:0] q1_reg, q2_reg, wd_reg;
    logic              f1_reg, f2_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        q1_reg <= mem[ra1];
        q2_reg <= mem[ra2];
        wd_reg <= wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else
        begin
            f1_reg <= we && (wa == ra1);
            f2_reg <= we && (wa == ra2);
        end
    end

    assign rd1 = f1_reg ? wd_reg : q1_reg;
    assign rd2 = f2_reg ? wd_reg : q2_reg;

endmodule

[hw/rtl/bgbd_out_fifo.sv]
// Output queue taking up to two items per cycle.
module bgbd_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_n,
    input  bgbd_pkg::out_item_t   push0,
    input  bgbd_pkg::out_item_t   push1,
    input  logic                  pop,
    output bgbd_pkg::out_item_t   head,
    output logic                  not_empty,
    output logic                  room
);
    import bgbd_pkg::*;

    out_item_t              entries [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wp_reg, rp_reg;
    logic [FIFO_AW:0]       count_reg;
    logic [FIFO_AW-1:0]     wp1;

    assign wp1       = wp_reg + 1'b1;
    assign head      = entries[rp_reg];
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 4));

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entries[wp_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            entries[wp1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + FIFO_AW'(push_n);
            rp_reg    <= rp_reg + FIFO_AW'(pop);
            count_reg <= count_reg + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
        end
    end

endmodule

[hw/rtl/bayer_gr12_bilinear_demosaic_unit.sv]
// Top level of the GRBG bilinear demosaic unit.
// Throughput: one input item per cycle while the output queue has room; results leave one per cycle when taken.
// An accepted item is registered together with its line RAM read; its results then pass through the output queue.
// Row ends give two results from one item; an 8-entry output queue absorbs them.
// Reset clears counters, window, stage control and queue and sets the frame to 1920x1080; line RAM stays undefined.
module bayer_gr12_bilinear_demosaic_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [11:0] raw_pixel
    input  logic [0:0]                          s_tuser,   // [0] flush
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // first, middle, last channel
    output logic                                m_tlast,
    output logic [0:0]                          m_tuser,   // [0] end_of_frame
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bgbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bgbd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bgbd_pkg::*;

    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int DW        = AW + 1;
    localparam int MAXW_EVEN = MAX_WIDTH & ~1;

    logic [12:0]      fw_reg;
    logic [15:0]      fh_reg;
    logic             order_reg;
    logic [AW-1:0]    col_reg, col_next;
    logic [15:0]      row_reg, row_next;
    logic [DW-1:0]    drain_reg, drain_next;
    window_t          win_reg, win_next;
    logic             b_valid_reg, b_valid_next;
    stage_ctl_t       b_ctl_reg, ctl_next;
    logic [7:0]       b_pix_reg;
    logic [AW-1:0]    b_addr_reg;

    logic [31:0]      fw_even, w_eff;
    logic [AW-1:0]    wm1, c, cm1, ra1;
    logic [DW-1:0]    w_drain;
    logic [15:0]      h_even, hm1, r;
    logic             in_fire;
    row_kind_t        kind_in;

    logic [PAIR_W-1:0] rd1, rd2;
    logic              we;
    window_t           w1, w2;
    rgb_t              px_a, px_b;
    out_item_t         item_a, item_b, head;
    logic [1:0]        push_n;
    logic              room, not_empty;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign in_fire   = s_tvalid && s_tready;

    always_comb
    begin
        fw_even = {19'd0, fw_reg[12:1], 1'b0};
        if (fw_even > 32'(MAXW_EVEN))
            w_eff = 32'(MAXW_EVEN);
        else if (fw_even < 32'd2)
            w_eff = 32'd2;
        else
            w_eff = fw_even;
        wm1     = AW'(w_eff - 32'd1);
        w_drain = DW'(w_eff);
        h_even  = {fh_reg[15:1], 1'b0};
        hm1     = (h_even < 16'd2) ? 16'd1 : h_even - 16'd1;
        c       = (col_reg < wm1) ? col_reg : wm1;
        r       = (row_reg < hm1) ? row_reg : hm1;
        cm1     = c - 1'b1;
        if (r == 16'd1)
            kind_in = ROW_FIRST;
        else if (!r[0])
            kind_in = ROW_ODD;
        else
            kind_in = ROW_EVEN;
    end

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        drain_next   = drain_reg;
        b_valid_next = 1'b0;
        ctl_next     = '0;
        ra1          = c;
        if (in_fire)
        begin
            if (s_tuser[0])
            begin
                if (drain_reg != '0)
                begin
                    b_valid_next     = 1'b1;
                    ctl_next.flush   = 1'b1;
                    ctl_next.emit_a  = 1'b1;
                    ctl_next.kind    = ROW_LAST;
                    ctl_next.a_first = (c == '0);
                    ctl_next.a_last  = (c == wm1);
                    ctl_next.a_odd   = c[0];
                    ctl_next.a_eof   = (drain_reg == DW'(1));
                    ctl_next.a_eol   = (drain_reg == DW'(1)) || (c == wm1);
                    ra1              = c + 1'b1;
                    drain_next       = drain_reg - 1'b1;
                    col_next         = (drain_reg == DW'(1)) ? '0 : c + 1'b1;
                end
            end
            else if (drain_reg == '0)
            begin
                b_valid_next      = 1'b1;
                ctl_next.kind     = kind_in;
                ctl_next.emit_a   = (r != '0) && (c != '0);
                ctl_next.emit_b   = (r != '0) && (c == wm1);
                ctl_next.a_first  = (cm1 == '0);
                ctl_next.a_odd    = cm1[0];
                ctl_next.load_pre = (c == wm1) && (r == hm1);
                if (c == wm1)
                begin
                    col_next = '0;
                    if (r == hm1)
                    begin
                        row_next   = '0;
                        drain_next = w_drain;
                    end
                    else
                    begin
                        row_next = r + 16'd1;
                    end
                end
                else
                begin
                    col_next = c + 1'b1;
                    row_next = r;
                end
            end
        end
    end

    bgbd_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .wa    (b_addr_reg),
        .wd    ({rd1[7:0], b_pix_reg}),
        .ra1   (ra1),
        .ra2   ('0),
        .rd1   (rd1),
        .rd2   (rd2)
    );

    assign we = b_valid_reg && !b_ctl_reg.flush;

    always_comb
    begin
        w1   = shift_win(win_reg, rd1[15:8], rd1[7:0], b_ctl_reg.flush ? 8'd0 : b_pix_reg);
        w2   = shift_win(w1, 8'd0, 8'd0, 8'd0);
        px_a = demosaic(w1, b_ctl_reg.kind, b_ctl_reg.a_first, b_ctl_reg.a_last,
                        b_ctl_reg.a_odd);
        px_b = demosaic(w2, b_ctl_reg.kind, 1'b0, 1'b1, 1'b1);
        item_a.first_ch = order_reg ? px_a.rd : px_a.bl;
        item_a.mid_ch   = px_a.gr;
        item_a.last_ch  = order_reg ? px_a.bl : px_a.rd;
        item_a.eol      = b_ctl_reg.a_eol;
        item_a.eof      = b_ctl_reg.a_eof;
        item_b.first_ch = order_reg ? px_b.rd : px_b.bl;
        item_b.mid_ch   = px_b.gr;
        item_b.last_ch  = order_reg ? px_b.bl : px_b.rd;
        item_b.eol      = 1'b1;
        item_b.eof      = 1'b0;
        push_n          = b_valid_reg ? ({1'b0, b_ctl_reg.emit_a} + {1'b0, b_ctl_reg.emit_b})
                                      : 2'd0;
        win_next        = win_reg;
        if (b_valid_reg)
        begin
            win_next = b_ctl_reg.emit_b ? w2 : w1;
            if (b_ctl_reg.load_pre)
            begin
                win_next[0][2] = rd2[15:8];
                win_next[1][2] = rd2[7:0];
            end
        end
    end

    bgbd_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push0     (item_a),
        .push1     (item_b),
        .pop       (m_tvalid && m_tready),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

    assign m_tvalid   = not_empty;
    assign m_tdata    = {head.last_ch, head.mid_ch, head.first_ch};
    assign m_tlast    = head.eol;
    assign m_tuser[0] = head.eof;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_pix_reg  <= s_tdata[11:4];
            b_addr_reg <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= 13'd1920;
            fh_reg      <= 16'd1080;
            order_reg   <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            drain_reg   <= '0;
            win_reg     <= '0;
            b_valid_reg <= 1'b0;
            b_ctl_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:   fw_reg    <= cfg_data[12:0];
                    REG_FRAME_HEIGHT:  fh_reg    <= cfg_data;
                    REG_CHANNEL_ORDER: order_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
            col_reg     <= col_next;
            row_reg     <= row_next;
            drain_reg   <= drain_next;
            win_reg     <= win_next;
            b_valid_reg <= b_valid_next;
            b_ctl_reg   <= ctl_next;
        end
    end

endmodule

[hw/rtl/bgbd_port_checker.sv]
// Port checker for the demosaic unit and its bind.
`include "bayer_gr12_bilinear_demosaic_unit_macros.svh"

module bgbd_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    `BGBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output item dropped")
    `BGBD_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "output data moved")
    `BGBD_ASSERT_SAME(a_eof_eol, m_tvalid && m_tuser[0], m_tlast, "frame end off row end")
    `BGBD_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")
endmodule

bind bayer_gr12_bilinear_demosaic_unit bgbd_port_checker u_port_checker (.*);

[dv/bayer_gr12_bilinear_demosaic_unit_test.sv]
// Testbench for the GRBG bilinear demosaic unit: predicts every color triple and checks it.
module bayer_gr12_bilinear_demosaic_unit_test;
    import bgbd_pkg::*;

    typedef struct packed {
        logic [7:0] first_ch;
        logic [7:0] mid_ch;
        logic [7:0] last_ch;
        logic       eol;
        logic       eof;
    } color_px_t;

    localparam int LINE_DEPTH  = 4096;
    localparam int CYCLE_LIMIT = 3000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [23:0]            m_tdata;
    logic                   m_tlast;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bayer_gr12_bilinear_demosaic_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [7:0]  prior_row [LINE_DEPTH];
    logic [7:0]  recent_row [LINE_DEPTH];
    logic [7:0]  win [3][3];
    int          row_idx = 0;
    int          col_idx = 0;
    int          drain_left = 0;
    int          width_reg = 1920;
    int          height_reg = 1080;
    bit          rgb_order = 1'b0;

    color_px_t   expected_px[$];
    int          errors = 0;
    int          pixels_checked = 0;
    int          items_sent = 0;
    int          frames_done = 0;
    int          cycles = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int          rx_stall = 0;
    int          hold_cnt = 0;

    function automatic logic [7:0] mean2(int a, int b);
        return 8'((a + b) / 2);
    endfunction

    function automatic logic [7:0] mean3(int a, int b, int c);
        return 8'((a + b + c) / 3);
    endfunction

    function automatic logic [7:0] mean4(int a, int b, int c, int d);
        return 8'((a + b + c + d) / 4);
    endfunction

    function automatic void emit_pixel(row_kind_t kind, int c, int w, bit eol, bit eof);
        int al, a, ar, l, s, r, bl_n, b, br;
        logic [7:0] blue, green, red;
        bit is_first, is_last, is_odd;
        color_px_t px;
        al = int'(win[0][0]); a = int'(win[0][1]); ar = int'(win[0][2]);
        l = int'(win[1][0]); s = int'(win[1][1]); r = int'(win[1][2]);
        bl_n = int'(win[2][0]); b = int'(win[2][1]); br = int'(win[2][2]);
        is_first = (c == 0);
        is_last = (c == w - 1);
        is_odd = c[0];
        case (kind)
            ROW_FIRST: begin
                if (is_first) begin blue = 8'(b); green = 8'(s); red = 8'(r); end
                else if (is_last) begin blue = 8'(bl_n); green = mean2(l, b); red = 8'(s); end
                else if (is_odd) begin
                    blue = mean2(bl_n, br); green = mean3(l, r, b); red = 8'(s);
                end
                else begin blue = 8'(b); green = 8'(s); red = mean2(l, r); end
            end
            ROW_ODD: begin
                if (is_first) begin
                    blue = 8'(s); green = mean3(a, r, b); red = mean2(ar, br);
                end
                else if (is_last) begin blue = 8'(l); green = 8'(s); red = mean2(a, b); end
                else if (is_odd) begin blue = mean2(l, r); green = 8'(s); red = mean2(a, b); end
                else begin
                    blue = 8'(s); green = mean4(a, b, l, r); red = mean4(al, ar, bl_n, br);
                end
            end
            ROW_EVEN: begin
                if (is_first) begin blue = mean2(a, b); green = 8'(s); red = 8'(r); end
                else if (is_last) begin
                    blue = mean2(bl_n, al); green = mean3(a, b, l); red = 8'(s);
                end
                else if (is_odd) begin
                    blue = mean4(al, ar, bl_n, br); green = mean4(a, b, l, r); red = 8'(s);
                end
                else begin blue = mean2(a, b); green = 8'(s); red = mean2(l, r); end
            end
            default: begin
                if (is_first) begin blue = 8'(s); green = mean2(a, r); red = 8'(ar); end
                else if (is_last) begin blue = 8'(l); green = 8'(s); red = 8'(a); end
                else if (is_odd) begin blue = mean2(l, r); green = 8'(s); red = 8'(a); end
                else begin blue = 8'(s); green = mean3(a, l, r); red = mean2(al, ar); end
            end
        endcase
        px.first_ch = rgb_order ? red : blue;
        px.mid_ch = green;
        px.last_ch = rgb_order ? blue : red;
        px.eol = eol;
        px.eof = eof;
        expected_px.push_back(px);
    endfunction

    function automatic void shift_window(logic [7:0] t, logic [7:0] m, logic [7:0] b);
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = t;
        win[1][2] = m;
        win[2][2] = b;
    endfunction

    function automatic void predict_item(logic [11:0] raw, logic fl);
        int w, h, c, r, cj;
        row_kind_t kind;
        logic [7:0] pix;
        bit last_drain;
        w = width_reg & ~1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (w < 2) w = 2;
        h = height_reg & ~1;
        if (h < 2) h = 2;
        c = (col_idx < w - 1) ? col_idx : w - 1;
        r = (row_idx < h - 1) ? row_idx : h - 1;
        if (fl) begin
            if (drain_left == 0) return;
            for (int j = 0; j < 3; j++) begin
                cj = c + j;
                win[0][j] = (cj >= 1 && cj <= w) ? prior_row[cj - 1] : 8'd0;
                win[1][j] = (cj >= 1 && cj <= w) ? recent_row[cj - 1] : 8'd0;
                win[2][j] = 8'd0;
            end
            last_drain = (drain_left == 1);
            emit_pixel(ROW_LAST, c, w, last_drain || c == w - 1, last_drain);
            drain_left--;
            col_idx = (drain_left == 0) ? 0 : c + 1;
            return;
        end
        if (drain_left != 0) return;
        pix = raw[11:4];
        shift_window(prior_row[c], recent_row[c], pix);
        prior_row[c] = recent_row[c];
        recent_row[c] = pix;
        if (r >= 1) begin
            if (r == 1) kind = ROW_FIRST;
            else kind = ((r - 1) % 2) ? ROW_ODD : ROW_EVEN;
            if (c >= 1) emit_pixel(kind, c - 1, w, 1'b0, 1'b0);
            if (c == w - 1) begin
                shift_window(8'd0, 8'd0, 8'd0);
                emit_pixel(kind, c, w, 1'b1, 1'b0);
            end
        end
        if (c == w - 1) begin
            col_idx = 0;
            if (r == h - 1) begin
                row_idx = 0;
                drain_left = w;
                frames_done++;
            end else begin
                row_idx = r + 1;
            end
        end else begin
            col_idx = c + 1;
            row_idx = r;
        end
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at pixel %0d: %s got %0d expected %0d", pixels_checked, what, got,
                 want);
        errors++;
    endtask

    // result checker
    always @(posedge clk) begin
        color_px_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_px.size() == 0) begin
                report("unexpected item", 1, 0);
            end else begin
                want = expected_px.pop_front();
                if (m_tdata[7:0] !== want.first_ch)
                    report("first channel", int'(m_tdata[7:0]), int'(want.first_ch));
                if (m_tdata[15:8] !== want.mid_ch)
                    report("middle channel", int'(m_tdata[15:8]), int'(want.mid_ch));
                if (m_tdata[23:16] !== want.last_ch)
                    report("last channel", int'(m_tdata[23:16]), int'(want.last_ch));
                if (m_tlast !== want.eol)
                    report("end of line", int'(m_tlast), int'(want.eol));
                if (m_tuser[0] !== want.eof)
                    report("end of frame", int'(m_tuser[0]), int'(want.eof));
            end
            pixels_checked++;
        end
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else if (hold_cnt != 0) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tready && m_tvalid) rx_stall = rx_burst ? 0 : $urandom_range(0, 16);
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(logic [11:0] raw, logic fl);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, raw};
        s_tuser <= fl;
        do @(posedge clk); while (!s_tready);
        predict_item(raw, fl);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH: width_reg = value & 16'h1FFF;
            REG_FRAME_HEIGHT: height_reg = value & 16'hFFFF;
            REG_CHANNEL_ORDER: rgb_order = value[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int w, int h, bit ord);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CHANNEL_ORDER, int'(ord));
    endtask

    function automatic logic [11:0] pick_pixel(int mode);
        case (mode)
            0: return 12'd0;
            1: return 12'hFFF;
            2: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // pixels of one frame, then the drain; noise adds stray flushes and dropped pixels
    task automatic run_frame(int w, int h, int mode, bit noise);
        if (noise) send_item(pick_pixel(3), 1'b1);
        for (int i = 0; i < w * h; i++) send_item(pick_pixel(mode), 1'b0);
        for (int i = 0; i < w; i++) begin
            if (noise && $urandom_range(0, 3) == 0) send_item(pick_pixel(3), 1'b0);
            send_item(pick_pixel(3), 1'b1);
        end
        if (noise) send_item(pick_pixel(3), 1'b1);
    endtask

    task automatic test_directed();
        set_geometry(0, 1, 0);
        run_frame(2, 2, 1, 1'b1);
        set_geometry(5, 3, 1);
        run_frame(4, 2, 2, 1'b0);
        wait_drained();
        write_reg(REG_CHANNEL_ORDER, 0);
        run_frame(4, 2, 0, 1'b0);
    endtask

    task automatic test_tall_frame();
        set_geometry(3, 65535, 1);
        for (int i = 0; i < 12; i++) send_item(pick_pixel(3), 1'b0);
        wait_drained();
        write_reg(REG_FRAME_HEIGHT, 2);
        send_item(pick_pixel(3), 1'b0);
        send_item(pick_pixel(3), 1'b0);
        send_item(pick_pixel(3), 1'b1);
        send_item(pick_pixel(3), 1'b1);
    endtask

    task automatic test_widest_row();
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        set_geometry(131, 2, 0);
        run_frame(130, 2, 3, 1'b0);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic test_backpressure();
        set_geometry(16, 4, 1);
        tx_burst = 1'b1;
        hold_cnt <= 300;
        run_frame(16, 4, 3, 1'b0);
        tx_burst = 1'b0;
    endtask

    task automatic test_random_frames();
        int w, h, stop_at;
        stop_at = items_sent + 480;
        while (items_sent < stop_at) begin
            w = 2 * $urandom_range(1, 12);
            h = 2 * $urandom_range(1, 4);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            set_geometry(w + $urandom_range(0, 1), h + $urandom_range(0, 1),
                         1'($urandom_range(0, 1)));
            run_frame(w, h, 3, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
            prior_row[i] = 8'd0;
            recent_row[i] = 8'd0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_tall_frame();
        test_widest_row();
        test_backpressure();
        test_random_frames();
        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d input items over %0d frames, checked %0d output pixels",
                 items_sent, frames_done, pixels_checked);
        $display("geometries from 2x2 up to 130 wide and 65535 tall, both channel orders");
        if (errors == 0 && expected_px.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
